// ===== design/dsm_pkg.sv =====
// ----------------------------------------------------------------------------
// dsm_pkg
// shared types, command codes and helpers of the dfa state minimizer
// ----------------------------------------------------------------------------
package dsm_pkg;

    localparam int ID_W    = 8;
    localparam int CNT_W   = 9;
    localparam int EP_W    = 18;
    localparam int KEY_W   = 2 * ID_W;
    localparam int CLR_W   = KEY_W;
    localparam int ADDR_W  = 5;

    // command codes
    localparam logic [2:0] CMD_LOAD_T = 3'd0;
    localparam logic [2:0] CMD_LOAD_A = 3'd1;
    localparam logic [2:0] CMD_RUN    = 3'd2;
    localparam logic [2:0] CMD_QMAP   = 3'd3;
    localparam logic [2:0] CMD_QENT   = 3'd4;

    // register indexes
    localparam logic [2:0] REG_STATE_COUNT   = 3'd0;
    localparam logic [2:0] REG_ALPHABET_SIZE = 3'd1;
    localparam logic [2:0] REG_START_FLOAT   = 3'd2;
    localparam logic [2:0] REG_START_ANCHOR  = 3'd3;
    localparam logic [2:0] REG_MIN_ENABLE    = 3'd4;

    typedef struct packed {
        logic [2:0]      cmd;
        logic [ID_W-1:0] state_id;
        logic [ID_W-1:0] symbol;
        logic [ID_W-1:0] target;
        logic [ID_W-1:0] report_class;
        logic [ID_W-1:0] parent;
    } t_item;

    typedef struct packed {
        logic [CNT_W-1:0] state_count;
        logic [CNT_W-1:0] alphabet_size;
        logic [ID_W-1:0]  start_floating;
        logic [ID_W-1:0]  start_anchored;
        logic             minimize_enable;
    } t_cfg;

    typedef struct packed {
        logic [EP_W-1:0] ep;
        logic [ID_W-1:0] id;
    } t_key;

    // effective count: zero acts as one, above the id range acts as the limit
    function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] r;
        r = v;
        if (v == '0) r = CNT_W'(1);
        if (v > CNT_W'(1 << ID_W)) r = CNT_W'(1 << ID_W);
        return r;
    endfunction

    // ids at or above the limit read as the last valid id
    function automatic logic [ID_W-1:0] clamp_id(input logic [CNT_W-1:0] x,
                                                 input logic [CNT_W-1:0] lim);
        logic [CNT_W-1:0] m;
        m = lim - CNT_W'(1);
        return (x < lim) ? x[ID_W-1:0] : m[ID_W-1:0];
    endfunction

endpackage

// ===== design/dfa_state_minimizer_unit.sv =====
// run: a clearing pass over all 65536 key-table entries, then the report class
// split, one refinement pass per symbol, sweeps over the alphabet until stable
// and a map build over all 256 ids; with minimization off a clamped identity
// map over 256 ids; a two-entry command queue accepts while the executor works;
// busy high when the queue is full
// synchronous active-low reset: identity map, one class, registers at reset
// ----------------------------------------------------------------------------
// dfa_state_minimizer_unit
// top level: register port, command queue and minimization executor
// ----------------------------------------------------------------------------
module dfa_state_minimizer_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [dsm_pkg::ADDR_W-1:0]         paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    input  logic                               start,
    output logic                               busy,
    input  logic [2:0]                         i_cmd,
    input  logic [dsm_pkg::ID_W-1:0]           i_state_id,
    input  logic [dsm_pkg::ID_W-1:0]           i_symbol,
    input  logic [dsm_pkg::ID_W-1:0]           i_target,
    input  logic [dsm_pkg::ID_W-1:0]           i_report_class,
    input  logic [dsm_pkg::ID_W-1:0]           i_parent,
    output logic                               o_strobe,
    output logic [dsm_pkg::CNT_W-1:0]          o_new_state_count,
    output logic [dsm_pkg::ID_W-1:0]           o_mapped_state,
    output logic [dsm_pkg::ID_W-1:0]           o_representative,
    output logic [dsm_pkg::ID_W-1:0]           o_new_parent,
    output logic [dsm_pkg::ID_W-1:0]           o_new_target,
    output logic [dsm_pkg::ID_W-1:0]           o_new_start_floating,
    output logic [dsm_pkg::ID_W-1:0]           o_new_start_anchored
);
    import dsm_pkg::*;

    t_cfg       r_cfg;
    t_item      in_item, q_item;
    logic       push, q_full, q_valid, pop, back_idle, wr;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr      = psel && penable && pwrite;
    assign reg_idx = paddr[ADDR_W-1:2];

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{state_count: CNT_W'(1), alphabet_size: CNT_W'(256),
                       start_floating: '0, start_anchored: '0, minimize_enable: 1'b1};
        end else if (wr) begin
            case (reg_idx)
                REG_STATE_COUNT:   r_cfg.state_count    <= pwdata[CNT_W-1:0];
                REG_ALPHABET_SIZE: r_cfg.alphabet_size  <= pwdata[CNT_W-1:0];
                REG_START_FLOAT:   r_cfg.start_floating <= pwdata[ID_W-1:0];
                REG_START_ANCHOR:  r_cfg.start_anchored <= pwdata[ID_W-1:0];
                REG_MIN_ENABLE:    r_cfg.minimize_enable <= pwdata[0];
                default: ;
            endcase
        end
    end

    // register reads
    always_comb begin
        case (reg_idx)
            REG_STATE_COUNT:   prdata = {23'd0, r_cfg.state_count};
            REG_ALPHABET_SIZE: prdata = {23'd0, r_cfg.alphabet_size};
            REG_START_FLOAT:   prdata = {24'd0, r_cfg.start_floating};
            REG_START_ANCHOR:  prdata = {24'd0, r_cfg.start_anchored};
            REG_MIN_ENABLE:    prdata = {31'd0, r_cfg.minimize_enable};
            default:           prdata = '0;
        endcase
    end

    // command transaction intake
    assign busy    = q_full;
    assign push    = start && !q_full;
    assign in_item = '{cmd: i_cmd, state_id: i_state_id, symbol: i_symbol,
                       target: i_target, report_class: i_report_class, parent: i_parent};

    dsm_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (in_item),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_pop   (pop)
    );

    dsm_back u_back (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg                (r_cfg),
        .i_valid              (q_valid),
        .i_item               (q_item),
        .o_pop                (pop),
        .o_idle               (back_idle),
        .o_strobe             (o_strobe),
        .o_new_state_count    (o_new_state_count),
        .o_mapped_state       (o_mapped_state),
        .o_representative     (o_representative),
        .o_new_parent         (o_new_parent),
        .o_new_target         (o_new_target),
        .o_new_start_floating (o_new_start_floating),
        .o_new_start_anchored (o_new_start_anchored)
    );

`ifndef SYNTHESIS
    // results are never back to back: every command runs through idle, execute and the start-state remap states
    a_strobe_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe) else $error("result strobes back to back");

    // class count is never zero
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_new_state_count != '0)) else $error("zero class count");

    // the executor is already idle while a result strobe is high
    a_idle_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> back_idle) else $error("executor busy at result");
`endif

endmodule

// ===== design/dsm_front.sv =====
// ----------------------------------------------------------------------------
// dsm_front
// command intake: two-entry queue between the port and the executor
// ----------------------------------------------------------------------------
module dsm_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  dsm_pkg::t_item i_item,
    output logic          o_full,
    output logic          o_valid,
    output dsm_pkg::t_item o_item,
    input  logic          i_pop
);
    import dsm_pkg::*;

    t_item      r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_mem[r_rp];

    // occupancy
    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !(i_pop && o_valid)) n_cnt = r_cnt + 2'd1;
        if (!i_push && i_pop && o_valid)   n_cnt = r_cnt - 2'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) r_wp <= ~r_wp;
            if (i_pop && o_valid) r_rp <= ~r_rp;
        end
    end

    // payload storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_item;
    end

endmodule

// ===== design/dsm_back.sv =====
// ----------------------------------------------------------------------------
// dsm_back
// executor: table loads, partition refinement sequencer and queries
// ----------------------------------------------------------------------------
module dsm_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  dsm_pkg::t_cfg               i_cfg,
    input  logic                        i_valid,
    input  dsm_pkg::t_item              i_item,
    output logic                        o_pop,
    output logic                        o_idle,
    output logic                        o_strobe,
    output logic [dsm_pkg::CNT_W-1:0]   o_new_state_count,
    output logic [dsm_pkg::ID_W-1:0]    o_mapped_state,
    output logic [dsm_pkg::ID_W-1:0]    o_representative,
    output logic [dsm_pkg::ID_W-1:0]    o_new_parent,
    output logic [dsm_pkg::ID_W-1:0]    o_new_target,
    output logic [dsm_pkg::ID_W-1:0]    o_new_start_floating,
    output logic [dsm_pkg::ID_W-1:0]    o_new_start_anchored
);
    import dsm_pkg::*;

    localparam logic [4:0] ST_IDLE = 5'd0;
    localparam logic [4:0] ST_EXEC = 5'd1;
    localparam logic [4:0] ST_QA   = 5'd2;
    localparam logic [4:0] ST_QB   = 5'd3;
    localparam logic [4:0] ST_QC   = 5'd4;
    localparam logic [4:0] ST_QD   = 5'd5;
    localparam logic [4:0] ST_QE   = 5'd6;
    localparam logic [4:0] ST_QF   = 5'd7;
    localparam logic [4:0] ST_S0   = 5'd8;
    localparam logic [4:0] ST_S1   = 5'd9;
    localparam logic [4:0] ST_S2   = 5'd10;
    localparam logic [4:0] ST_DIS  = 5'd11;
    localparam logic [4:0] ST_CLR  = 5'd12;
    localparam logic [4:0] ST_I0   = 5'd13;
    localparam logic [4:0] ST_I1   = 5'd14;
    localparam logic [4:0] ST_I2   = 5'd15;
    localparam logic [4:0] ST_P0   = 5'd16;
    localparam logic [4:0] ST_P1   = 5'd17;
    localparam logic [4:0] ST_P2   = 5'd18;
    localparam logic [4:0] ST_P3   = 5'd19;
    localparam logic [4:0] ST_F0   = 5'd20;
    localparam logic [4:0] ST_F1   = 5'd21;

    localparam int NID = 1 << ID_W;

    // memories
    logic [ID_W-1:0] tt_mem   [1 << KEY_W];
    logic [ID_W-1:0] rcls_mem [NID];
    logic [ID_W-1:0] par_mem  [NID];
    logic [ID_W-1:0] blk_mem  [2 * NID];
    t_key            key_mem  [1 << KEY_W];
    logic [ID_W-1:0] map_mem  [NID];
    logic [ID_W-1:0] rep_mem  [NID];

    // memory ports
    logic              tt_we;
    logic [KEY_W-1:0]  tt_wa, tt_ra;
    logic [ID_W-1:0]   tt_wd, tt_q;
    logic              attr_we;
    logic [ID_W-1:0]   rcls_ra, par_ra, rcls_q, par_q;
    logic              blk_we;
    logic [ID_W:0]     blk_wa, blk_ra_a, blk_ra_b;
    logic [ID_W-1:0]   blk_wd, blk_qa, blk_qb;
    logic              key_we;
    logic [KEY_W-1:0]  key_wa, key_ra;
    t_key              key_wd, key_q;
    logic              map_we, rep_we;
    logic [ID_W-1:0]   map_wa, map_wd, map_ra, map_q, r_map_ra_q;
    logic [ID_W-1:0]   rep_wa, rep_wd, rep_ra, rep_q, r_rep_ra_q;

    // control and payload registers
    logic [4:0]       r_st, n_st;
    t_item            r_item, n_item;
    logic             r_ran, n_ran;
    logic [CNT_W-1:0] r_total, n_total;
    logic [ID_W-1:0]  r_mapped, n_mapped, r_rep, n_rep, r_npar, n_npar;
    logic [ID_W-1:0]  r_ntgt, n_ntgt, r_nsf, n_nsf, r_nsa, n_nsa, r_tq, n_tq;
    logic [CNT_W-1:0] r_s, n_s, r_c, n_c, r_k, n_k, r_cnt, n_cnt;
    logic             r_chg, n_chg, r_cb, n_cb, r_strobe, n_strobe;
    logic [EP_W-1:0]  r_ep, n_ep;
    logic [CLR_W-1:0] r_clr, n_clr;
    logic [KEY_W-1:0] r_kaddr, n_kaddr;

    logic [CNT_W-1:0] eff_n, eff_a, kk;
    logic [ID_W-1:0]  mapval, repval, kid;
    logic             hit, chg2;

    assign eff_n  = eff_count(i_cfg.state_count);
    assign eff_a  = eff_count(i_cfg.alphabet_size);
    // before the first run the map and representatives are the identity
    assign mapval = r_ran ? map_q : r_map_ra_q;
    assign repval = r_ran ? rep_q : r_rep_ra_q;
    // first-appearance numbering of block keys
    assign hit    = (key_q.ep == r_ep);
    assign kid    = hit ? key_q.id : r_k[ID_W-1:0];
    assign kk     = r_k + CNT_W'(!hit);
    assign chg2   = r_chg | (kk != r_cnt);

    assign o_pop  = (r_st == ST_IDLE) && i_valid;
    assign o_idle = (r_st == ST_IDLE);

    // sequencer
    always_comb begin
        n_st = r_st; n_item = r_item; n_ran = r_ran; n_total = r_total;
        n_mapped = r_mapped; n_rep = r_rep; n_npar = r_npar; n_ntgt = r_ntgt;
        n_nsf = r_nsf; n_nsa = r_nsa; n_tq = r_tq; n_s = r_s; n_c = r_c;
        n_k = r_k; n_cnt = r_cnt; n_chg = r_chg; n_cb = r_cb; n_ep = r_ep;
        n_clr = r_clr; n_kaddr = r_kaddr; n_strobe = 1'b0;
        tt_we = 1'b0; tt_wa = {r_item.state_id, r_item.symbol};
        tt_wd = r_item.target; tt_ra = '0;
        attr_we = 1'b0; rcls_ra = '0; par_ra = '0;
        blk_we = 1'b0; blk_wa = {~r_cb, r_s[ID_W-1:0]}; blk_wd = kid;
        blk_ra_a = '0; blk_ra_b = '0;
        key_we = 1'b0; key_wa = r_kaddr; key_wd = '{ep: r_ep, id: r_k[ID_W-1:0]};
        key_ra = '0;
        map_we = 1'b0; map_wa = r_s[ID_W-1:0]; map_wd = '0; map_ra = '0;
        rep_we = 1'b0; rep_wa = '0; rep_wd = '0; rep_ra = '0;
        case (r_st)
            ST_IDLE: begin
                if (i_valid) begin
                    n_item = i_item;
                    n_mapped = '0; n_rep = '0; n_npar = '0; n_ntgt = '0;
                    n_st = ST_EXEC;
                end
            end
            ST_EXEC: begin
                case (r_item.cmd)
                    CMD_LOAD_T: begin tt_we = 1'b1; n_st = ST_S0; end
                    CMD_LOAD_A: begin attr_we = 1'b1; n_st = ST_S0; end
                    CMD_RUN: begin
                        n_s = '0;
                        n_clr = '0;
                        n_st = i_cfg.minimize_enable ? ST_CLR : ST_DIS;
                    end
                    CMD_QMAP, CMD_QENT: n_st = ST_QA;
                    default: n_st = ST_S0;
                endcase
            end
            // query chain
            ST_QA: begin
                map_ra = clamp_id({1'b0, r_item.state_id}, eff_n);
                n_st = ST_QB;
            end
            ST_QB: begin
                n_mapped = (r_item.cmd == CMD_QMAP) ? mapval
                         : clamp_id({1'b0, r_item.state_id}, r_total);
                rep_ra = n_mapped;
                n_st = ST_QC;
            end
            ST_QC: begin
                n_rep = repval;
                par_ra = repval;
                tt_ra = {repval, clamp_id({1'b0, r_item.symbol}, eff_a)};
                n_st = ST_QD;
            end
            ST_QD: begin
                map_ra = clamp_id({1'b0, par_q}, eff_n);
                n_tq = tt_q;
                n_st = ST_QE;
            end
            ST_QE: begin
                n_npar = mapval;
                map_ra = clamp_id({1'b0, r_tq}, eff_n);
                n_st = (r_item.cmd == CMD_QENT) ? ST_QF : ST_S0;
            end
            ST_QF: begin
                n_ntgt = mapval;
                n_st = ST_S0;
            end
            // remapped start states, then the result
            ST_S0: begin
                map_ra = clamp_id({1'b0, i_cfg.start_floating}, eff_n);
                n_st = ST_S1;
            end
            ST_S1: begin
                n_nsf = mapval;
                map_ra = clamp_id({1'b0, i_cfg.start_anchored}, eff_n);
                n_st = ST_S2;
            end
            ST_S2: begin
                n_nsa = mapval;
                n_strobe = 1'b1;
                n_st = ST_IDLE;
            end
            // minimization off: clamped identity map and identity representatives
            ST_DIS: begin
                map_we = 1'b1;
                map_wd = clamp_id(r_s, eff_n);
                rep_we = 1'b1;
                rep_wa = r_s[ID_W-1:0];
                rep_wd = r_s[ID_W-1:0];
                if (r_s == CNT_W'(NID - 1)) begin
                    n_total = eff_n; n_ran = 1'b1; n_st = ST_S0;
                end else begin
                    n_s = r_s + CNT_W'(1);
                end
            end
            // key table clearing pass
            ST_CLR: begin
                key_we = 1'b1;
                key_wa = r_clr;
                key_wd = '0;
                if (r_clr == '1) begin
                    n_s = '0; n_k = '0; n_ep = EP_W'(1); n_st = ST_I0;
                end else begin
                    n_clr = r_clr + CLR_W'(1);
                end
            end
            // initial split by report class
            ST_I0: begin
                rcls_ra = r_s[ID_W-1:0];
                n_st = ST_I1;
            end
            ST_I1: begin
                key_ra = {{ID_W{1'b0}}, rcls_q};
                n_kaddr = key_ra;
                n_st = ST_I2;
            end
            ST_I2: begin
                key_we = !hit;
                blk_we = 1'b1;
                n_k = kk;
                if (r_s == eff_n - CNT_W'(1)) begin
                    n_cnt = kk; n_cb = ~r_cb; n_ep = r_ep + EP_W'(1);
                    n_k = '0; n_c = '0; n_chg = 1'b0; n_s = '0; n_st = ST_P0;
                end else begin
                    n_s = r_s + CNT_W'(1); n_st = ST_I0;
                end
            end
            // refinement on one symbol, one state at a time
            ST_P0: begin
                tt_ra = {r_s[ID_W-1:0], r_c[ID_W-1:0]};
                n_st = ST_P1;
            end
            ST_P1: begin
                blk_ra_a = {r_cb, r_s[ID_W-1:0]};
                blk_ra_b = {r_cb, clamp_id({1'b0, tt_q}, eff_n)};
                n_st = ST_P2;
            end
            ST_P2: begin
                key_ra = {blk_qa, blk_qb};
                n_kaddr = key_ra;
                n_st = ST_P3;
            end
            ST_P3: begin
                key_we = !hit;
                blk_we = 1'b1;
                n_k = kk;
                if (r_s == eff_n - CNT_W'(1)) begin
                    n_cnt = kk; n_cb = ~r_cb; n_ep = r_ep + EP_W'(1);
                    n_k = '0; n_s = '0;
                    if (r_c == eff_a - CNT_W'(1)) begin
                        n_c = '0; n_chg = 1'b0;
                        if (chg2) begin
                            n_st = ST_P0;
                        end else begin
                            n_s = CNT_W'(NID - 1); n_st = ST_F0;
                        end
                    end else begin
                        n_c = r_c + CNT_W'(1); n_chg = chg2; n_st = ST_P0;
                    end
                end else begin
                    n_s = r_s + CNT_W'(1); n_st = ST_P0;
                end
            end
            // build map and representatives, highest state first
            ST_F0: begin
                blk_ra_a = {r_cb, clamp_id(r_s, eff_n)};
                n_st = ST_F1;
            end
            ST_F1: begin
                map_we = 1'b1;
                map_wd = blk_qa;
                rep_we = (r_s < eff_n);
                rep_wa = blk_qa;
                rep_wd = r_s[ID_W-1:0];
                if (r_s == '0) begin
                    n_total = r_cnt; n_ran = 1'b1; n_st = ST_S0;
                end else begin
                    n_s = r_s - CNT_W'(1); n_st = ST_F0;
                end
            end
            default: n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= ST_IDLE;
            r_ran    <= 1'b0;
            r_total  <= CNT_W'(1);
            r_strobe <= 1'b0;
            r_cb     <= 1'b0;
        end else begin
            r_st     <= n_st;
            r_ran    <= n_ran;
            r_total  <= n_total;
            r_strobe <= n_strobe;
            r_cb     <= n_cb;
        end
    end

    // payload and loop registers
    always_ff @(posedge i_clk) begin
        r_item <= n_item; r_mapped <= n_mapped; r_rep <= n_rep; r_npar <= n_npar;
        r_ntgt <= n_ntgt; r_nsf <= n_nsf; r_nsa <= n_nsa; r_tq <= n_tq;
        r_s <= n_s; r_c <= n_c; r_k <= n_k; r_cnt <= n_cnt; r_chg <= n_chg;
        r_ep <= n_ep; r_clr <= n_clr; r_kaddr <= n_kaddr;
        r_map_ra_q <= map_ra; r_rep_ra_q <= rep_ra;
    end

    // memory ports
    always_ff @(posedge i_clk) begin
        if (tt_we) tt_mem[tt_wa] <= tt_wd;
        tt_q <= tt_mem[tt_ra];
    end

    always_ff @(posedge i_clk) begin
        if (attr_we) begin
            rcls_mem[r_item.state_id] <= r_item.report_class;
            par_mem[r_item.state_id]  <= r_item.parent;
        end
        rcls_q <= rcls_mem[rcls_ra];
        par_q  <= par_mem[par_ra];
    end

    always_ff @(posedge i_clk) begin
        if (blk_we) blk_mem[blk_wa] <= blk_wd;
        blk_qa <= blk_mem[blk_ra_a];
        blk_qb <= blk_mem[blk_ra_b];
    end

    always_ff @(posedge i_clk) begin
        if (key_we) key_mem[key_wa] <= key_wd;
        key_q <= key_mem[key_ra];
    end

    always_ff @(posedge i_clk) begin
        if (map_we) map_mem[map_wa] <= map_wd;
        map_q <= map_mem[map_ra];
    end

    always_ff @(posedge i_clk) begin
        if (rep_we) rep_mem[rep_wa] <= rep_wd;
        rep_q <= rep_mem[rep_ra];
    end

    assign o_strobe             = r_strobe;
    assign o_new_state_count    = r_total;
    assign o_mapped_state       = r_mapped;
    assign o_representative     = r_rep;
    assign o_new_parent         = r_npar;
    assign o_new_target         = r_ntgt;
    assign o_new_start_floating = r_nsf;
    assign o_new_start_anchored = r_nsa;

endmodule
